FILE: src/decimal_text_to_fixed_point_core_defines.svh
// Assertion macros for the decimal text to fixed point core
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DTFP_ASSERT(label, clock, reset_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) else $error(msg);

`define DTFP_ASSERT_NEXT(label, clock, reset_n, cause, effect, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (cause) |=> (effect)) \
		else $error(msg);

`else

`define DTFP_ASSERT(label, clock, reset_n, prop, msg)

`define DTFP_ASSERT_NEXT(label, clock, reset_n, cause, effect, msg)

`endif

`endif

FILE: src/dtfp_pkg.sv
`timescale 1ns / 1ps

package dtfp_pkg;

	localparam int FRACTION_BITS_DEF       = 32;
	localparam int MAX_FRACTION_DIGITS_DEF = 10;

	localparam int CHAR_BITS   = 8;
	localparam int INT_BITS    = 31;
	localparam int FRAC_BITS   = 34;
	localparam int COUNT_BITS  = 4;
	localparam int VALUE_BITS  = 64;

	localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_DIV,
		SQ_ROUND,
		SQ_HOLD
	} seq_t;

	typedef struct packed {
		logic                  negative;
		logic [INT_BITS-1:0]   int_part;
		logic                  overflow;
		logic [FRAC_BITS-1:0]  frac_value;
		logic [COUNT_BITS-1:0] frac_count;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} div_status_t;

	function automatic logic [FRAC_BITS-1:0] pow_ten(input logic [COUNT_BITS-1:0] n);
		logic [FRAC_BITS-1:0] p;
		case (n)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			4'd10:   p = 34'd10000000000;
			default: p = 34'd1;
		endcase
		return p;
	endfunction

endpackage

FILE: src/dtfp_parser.sv
`timescale 1ns / 1ps

module dtfp_parser #(
	parameter int MAX_FRACTION_DIGITS = dtfp_pkg::MAX_FRACTION_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [dtfp_pkg::CHAR_BITS-1:0]    character,
	input  logic                              start_of_string,
	output logic                              terminate,
	output dtfp_pkg::div_req_t                req
);

	dtfp_pkg::phase_t                    phase_q, phase_e, phase_n;
	logic                                negative_q, negative_e, negative_n;
	logic [dtfp_pkg::INT_BITS-1:0]       int_q, int_e, int_n;
	logic                                ovf_q, ovf_e, ovf_n;
	logic [dtfp_pkg::FRAC_BITS-1:0]      frac_q, frac_e, frac_n;
	logic [dtfp_pkg::COUNT_BITS-1:0]     cnt_q, cnt_e, cnt_n;

	logic                                is_digit, is_blank, is_minus, is_plus, is_point;
	logic [3:0]                          digit;
	logic [dtfp_pkg::INT_BITS+3:0]       int_mul;
	logic [dtfp_pkg::FRAC_BITS-1:0]      frac_mul;

	assign is_digit = character inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]};
	assign is_blank = (character == dtfp_pkg::CH_SPACE)
		|| (character inside {[dtfp_pkg::CH_TAB:dtfp_pkg::CH_CR]});
	assign is_minus = character == dtfp_pkg::CH_MINUS;
	assign is_plus  = character == dtfp_pkg::CH_PLUS;
	assign is_point = character == dtfp_pkg::CH_POINT;
	assign digit    = character[3:0];

	always_comb begin
		if (start_of_string) begin
			phase_e    = dtfp_pkg::PH_BLANK;
			negative_e = 1'b0;
			int_e      = '0;
			ovf_e      = 1'b0;
			frac_e     = '0;
			cnt_e      = '0;
		end else begin
			phase_e    = phase_q;
			negative_e = negative_q;
			int_e      = int_q;
			ovf_e      = ovf_q;
			frac_e     = frac_q;
			cnt_e      = cnt_q;
		end
	end

	assign int_mul  = ({4'b0, int_e} << 3) + ({4'b0, int_e} << 1)
		+ (dtfp_pkg::INT_BITS+4)'(digit);
	assign frac_mul = (frac_e << 3) + (frac_e << 1) + dtfp_pkg::FRAC_BITS'(digit);

	// next state
	always_comb begin
		logic take_int, take_frac;
		take_int  = 1'b0;
		take_frac = 1'b0;
		phase_n    = phase_e;
		negative_n = negative_e;
		case (phase_e)
			dtfp_pkg::PH_BLANK: begin
				if (is_blank) begin
					phase_n = dtfp_pkg::PH_BLANK;
				end else if (is_minus) begin
					negative_n = 1'b1;
					phase_n    = dtfp_pkg::PH_INT;
				end else if (is_plus) begin
					phase_n = dtfp_pkg::PH_INT;
				end else if (is_digit) begin
					take_int = 1'b1;
					phase_n  = dtfp_pkg::PH_INT;
				end else if (is_point) begin
					phase_n = dtfp_pkg::PH_FRAC;
				end else begin
					phase_n = dtfp_pkg::PH_DONE;
				end
			end
			dtfp_pkg::PH_INT: begin
				if (is_digit) begin
					take_int = 1'b1;
				end else if (is_point) begin
					phase_n = dtfp_pkg::PH_FRAC;
				end else begin
					phase_n = dtfp_pkg::PH_DONE;
				end
			end
			dtfp_pkg::PH_FRAC: begin
				if (is_digit) begin
					take_frac = 1'b1;
				end else begin
					phase_n = dtfp_pkg::PH_DONE;
				end
			end
			default: begin
				phase_n = dtfp_pkg::PH_DONE;
			end
		endcase

		int_n = int_e;
		ovf_n = ovf_e;
		if (take_int) begin
			if (int_mul > (dtfp_pkg::INT_BITS+4)'({dtfp_pkg::INT_BITS{1'b1}})) begin
				int_n = '1;
				ovf_n = 1'b1;
			end else begin
				int_n = int_mul[dtfp_pkg::INT_BITS-1:0];
			end
		end

		frac_n = frac_e;
		cnt_n  = cnt_e;
		if (take_frac && (cnt_e < dtfp_pkg::COUNT_BITS'(MAX_FRACTION_DIGITS))) begin
			frac_n = frac_mul;
			cnt_n  = cnt_e + 1'b1;
		end
	end

	// outputs
	always_comb begin
		case (phase_e)
			dtfp_pkg::PH_BLANK: terminate = !(is_blank || is_minus || is_plus
				|| is_digit || is_point);
			dtfp_pkg::PH_INT:   terminate = !(is_digit || is_point);
			dtfp_pkg::PH_FRAC:  terminate = !is_digit;
			default:            terminate = 1'b0;
		endcase
		req.negative   = negative_e;
		req.int_part   = int_e;
		req.overflow   = ovf_e;
		req.frac_value = frac_e;
		req.frac_count = cnt_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dtfp_pkg::PH_BLANK;
			negative_q <= 1'b0;
			int_q      <= '0;
			ovf_q      <= 1'b0;
			frac_q     <= '0;
			cnt_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			negative_q <= negative_n;
			int_q      <= int_n;
			ovf_q      <= ovf_n;
			frac_q     <= frac_n;
			cnt_q      <= cnt_n;
		end
	end

endmodule

FILE: src/dtfp_divider.sv
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_core_defines.svh"

module dtfp_divider #(
	parameter int FRACTION_BITS = dtfp_pkg::FRACTION_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  dtfp_pkg::div_req_t                      req,
	input  logic                                    res_take,
	output dtfp_pkg::div_status_t                   status,
	output logic [dtfp_pkg::VALUE_BITS-1:0]         res_value,
	output logic                                    res_saturated
);

	localparam int MAG_BITS = dtfp_pkg::INT_BITS + FRACTION_BITS;
	localparam int CNT_W    = $clog2(FRACTION_BITS);

	dtfp_pkg::seq_t                     seq_q, seq_n;
	logic [CNT_W-1:0]                   bit_q;
	logic [dtfp_pkg::FRAC_BITS-1:0]     rem_q, den_q;
	logic [FRACTION_BITS-1:0]           quo_q;
	logic [dtfp_pkg::INT_BITS-1:0]      int_q;
	logic                               neg_q, ovf_q, sat_q;
	logic [MAG_BITS-1:0]                mag_q;

	logic [dtfp_pkg::FRAC_BITS:0]       rem_dbl;
	logic                               rem_ge;
	logic [FRACTION_BITS:0]             quo_rnd;
	logic [MAG_BITS:0]                  mag_sum;
	logic                               last_bit;
	logic [dtfp_pkg::VALUE_BITS-1:0]    mag_ext;

	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_ge   = rem_dbl >= {1'b0, den_q};
	assign last_bit = bit_q == CNT_W'(FRACTION_BITS - 1);
	assign quo_rnd  = (FRACTION_BITS+1)'(quo_q) + (FRACTION_BITS+1)'(rem_ge);
	assign mag_sum  = {1'b0, int_q, {FRACTION_BITS{1'b0}}} + (MAG_BITS+1)'(quo_rnd);
	assign mag_ext  = dtfp_pkg::VALUE_BITS'(mag_q);

	// next state
	always_comb begin
		case (seq_q)
			dtfp_pkg::SQ_IDLE:  seq_n = start ? dtfp_pkg::SQ_DIV : dtfp_pkg::SQ_IDLE;
			dtfp_pkg::SQ_DIV:   seq_n = last_bit ? dtfp_pkg::SQ_ROUND : dtfp_pkg::SQ_DIV;
			dtfp_pkg::SQ_ROUND: seq_n = dtfp_pkg::SQ_HOLD;
			dtfp_pkg::SQ_HOLD:  seq_n = res_take ? dtfp_pkg::SQ_IDLE : dtfp_pkg::SQ_HOLD;
			default:            seq_n = dtfp_pkg::SQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		status.busy      = seq_q != dtfp_pkg::SQ_IDLE;
		status.res_valid = seq_q == dtfp_pkg::SQ_HOLD;
		res_value        = neg_q ? (dtfp_pkg::VALUE_BITS'(0) - mag_ext) : mag_ext;
		res_saturated    = sat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= dtfp_pkg::SQ_IDLE;
		end else begin
			seq_q <= seq_n;
		end
	end

	always_ff @(posedge clk) begin
		case (seq_q)
			dtfp_pkg::SQ_IDLE: begin
				if (start) begin
					rem_q <= req.frac_value;
					den_q <= dtfp_pkg::pow_ten(req.frac_count);
					quo_q <= '0;
					bit_q <= '0;
					int_q <= req.int_part;
					neg_q <= req.negative;
					ovf_q <= req.overflow;
				end
			end
			dtfp_pkg::SQ_DIV: begin
				rem_q <= rem_ge ? dtfp_pkg::FRAC_BITS'(rem_dbl - {1'b0, den_q})
					: rem_dbl[dtfp_pkg::FRAC_BITS-1:0];
				quo_q <= {quo_q[FRACTION_BITS-2:0], rem_ge};
				bit_q <= bit_q + 1'b1;
			end
			dtfp_pkg::SQ_ROUND: begin
				if (ovf_q || mag_sum[MAG_BITS]) begin
					mag_q <= '1;
					sat_q <= 1'b1;
				end else begin
					mag_q <= mag_sum[MAG_BITS-1:0];
					sat_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	`DTFP_ASSERT(a_start_idle, clk, arst_n, start |-> seq_q == dtfp_pkg::SQ_IDLE, "start while busy")
	`DTFP_ASSERT(a_rem_below, clk, arst_n, (seq_q == dtfp_pkg::SQ_DIV) |-> (rem_q < den_q), "remainder not below divisor")
	`DTFP_ASSERT_NEXT(a_div_end, clk, arst_n, seq_q == dtfp_pkg::SQ_DIV && last_bit, seq_q == dtfp_pkg::SQ_ROUND, "division did not end on last bit")
	`DTFP_ASSERT_NEXT(a_res_hold, clk, arst_n, status.res_valid && !res_take, status.res_valid && $stable(res_value) && $stable(res_saturated), "result changed while held")

endmodule

FILE: src/decimal_text_to_fixed_point_core.sv
`timescale 1ns / 1ps
// A character that continues the number updates the parser state. The character
// that ends the number starts the one-bit-per-cycle fraction divider, whose
// rounded result is held until the output register takes it.
// Throughput: one character per cycle inside a number; after the ending
// character the input stalls until the divider's result is taken, which out_stall can delay.
// Reset: asynchronous, active low; clears parse phase, sequencer and out_valid.

module decimal_text_to_fixed_point_core #(
	parameter int FRACTION_BITS       = dtfp_pkg::FRACTION_BITS_DEF,
	parameter int MAX_FRACTION_DIGITS = dtfp_pkg::MAX_FRACTION_DIGITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [dtfp_pkg::CHAR_BITS-1:0]        character,
	input  logic                                  start_of_string,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dtfp_pkg::VALUE_BITS-1:0] value,
	output logic                                  saturated
);

	logic                               accept, terminate, res_take;
	dtfp_pkg::div_req_t                 req;
	dtfp_pkg::div_status_t              status;
	logic [dtfp_pkg::VALUE_BITS-1:0]    res_value;
	logic                               res_saturated;
	logic                               out_valid_q;
	logic [dtfp_pkg::VALUE_BITS-1:0]    value_q;
	logic                               saturated_q;

	assign in_stall = status.busy;
	assign accept   = in_valid && !in_stall;
	assign res_take = status.res_valid && (!out_valid_q || !out_stall);

	dtfp_parser #(
		.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.character       (character),
		.start_of_string (start_of_string),
		.terminate       (terminate),
		.req             (req)
	);

	dtfp_divider #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_divider (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (accept && terminate),
		.req           (req),
		.res_take      (res_take),
		.status        (status),
		.res_value     (res_value),
		.res_saturated (res_saturated)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			value_q     <= res_value;
			saturated_q <= res_saturated;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign saturated = saturated_q;

endmodule
